// ===== design/piaw_pkg.sv =====
// piaw_pkg: constants, types and the control-program table of the PI controller.
// Used by piaw_if.sv, piaw_sequencer.sv and pi_controller_antiwindup_unit.sv.
package piaw_pkg;

  // accumulator format
  localparam int AccWidth    = 48;
  localparam int AccFracBits = 24;

  // field and register widths
  localparam int SampleW  = 16;
  localparam int ErrW     = SampleW + 1;
  localparam int KpW      = 24;
  localparam int InvTiW   = 24;
  localparam int PeriodW  = 24;
  localparam int LimitW   = 31;
  localparam int OutW     = 32;
  localparam int ClampW   = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(65536);

  // shared multiplier: 32 x 24, registered product
  localparam int MulAW = 32;
  localparam int MulBW = 24;
  localparam int ProdW = MulAW + MulBW;

  // intermediate results are held at or below 2^62
  localparam int CapW = 63;
  localparam logic [CapW-1:0] BigCap = {1'b1, {(CapW-1){1'b0}}};

  localparam int IntegShift = AccFracBits + 12 - 16;
  localparam int KpShift    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP     = 2'd0,
    REG_INV_TI = 2'd1,
    REG_PERIOD = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [ClampW-1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_UPPER = 2'd1,
    CLAMP_LOWER = 2'd2
  } clamp_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_ERR_PERIOD,
    MUL_TENT_LO,
    MUL_TENT_HI,
    MUL_TOT_LO,
    MUL_TOT_HI
  } mul_sel_e;

  // datapath operation of a step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_TENT,
    OP_INTEG,
    OP_TOTAL,
    OP_OUT
  } op_e;

  // sequencing of a step
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT,
    SEQ_JUMP
  } seq_e;

  localparam int NumSteps = 10;
  localparam int StepW    = $clog2(NumSteps);
  localparam logic [StepW-1:0] StepStart = '0;

  typedef struct packed {
    op_e              op;
    mul_sel_e         mul_sel;
    logic             plo_en;
    seq_e             seq;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_cond_t;

  typedef struct packed {
    ctrl_t word;
    logic  go;
  } seq_out_t;

  // control program
  function automatic ctrl_t seq_rom(input logic [StepW-1:0] addr);
    ctrl_t w;
    w.op      = OP_NONE;
    w.mul_sel = MUL_ERR_PERIOD;
    w.plo_en  = 1'b0;
    w.seq     = SEQ_NEXT;
    w.target  = StepStart;
    unique case (addr)
      StepW'(0): begin
        w.op  = OP_LOAD;
        w.seq = SEQ_WAIT_IN;
      end
      StepW'(1): w.mul_sel = MUL_ERR_PERIOD;
      StepW'(2): w.op = OP_TENT;
      StepW'(3): w.mul_sel = MUL_TENT_LO;
      StepW'(4): begin
        w.mul_sel = MUL_TENT_HI;
        w.plo_en  = 1'b1;
      end
      StepW'(5): w.op = OP_INTEG;
      StepW'(6): w.op = OP_TOTAL;
      StepW'(7): w.mul_sel = MUL_TOT_LO;
      StepW'(8): begin
        w.mul_sel = MUL_TOT_HI;
        w.plo_en  = 1'b1;
      end
      StepW'(9): begin
        w.op  = OP_OUT;
        w.seq = SEQ_WAIT_OUT;
      end
      default: w.seq = SEQ_JUMP;
    endcase
    return w;
  endfunction

endpackage

// ===== design/piaw_if.sv =====
// piaw_if: valid/ready stream interfaces for samples and results.
// Depends on piaw_pkg for field widths.
interface piaw_sample_if;
  logic                         valid;
  logic                         ready;
  logic [piaw_pkg::SampleW-1:0] setpoint;
  logic [piaw_pkg::SampleW-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface piaw_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [piaw_pkg::OutW-1:0] control_output;
  logic [piaw_pkg::ClampW-1:0]      clamp_state;

  modport source (output valid, output control_output, output clamp_state, input ready);
  modport sink   (input valid, input control_output, input clamp_state, output ready);
endinterface

// ===== design/piaw_sequencer.sv =====
// piaw_sequencer: step counter and control table of the PI controller.
// Depends on piaw_pkg (ctrl_t, seq_rom).
module piaw_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  piaw_pkg::seq_cond_t cond_i,
  output piaw_pkg::seq_out_t  seq_o
);

  logic [piaw_pkg::StepW-1:0] step_q, step_d;
  piaw_pkg::ctrl_t            word;
  logic                       go;

  assign word = piaw_pkg::seq_rom(step_q);

  always_comb begin
    unique case (word.seq)
      piaw_pkg::SEQ_NEXT: begin
        go     = 1'b1;
        step_d = step_q + 1'b1;
      end
      piaw_pkg::SEQ_WAIT_IN: begin
        go     = cond_i.in_valid;
        step_d = go ? step_q + 1'b1 : step_q;
      end
      piaw_pkg::SEQ_WAIT_OUT: begin
        go     = cond_i.out_free;
        step_d = go ? word.target : step_q;
      end
      piaw_pkg::SEQ_JUMP: begin
        go     = 1'b1;
        step_d = word.target;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= piaw_pkg::StepStart;
    end else begin
      step_q <= step_d;
    end
  end

  assign seq_o.word = word;
  assign seq_o.go   = go;

endmodule

// ===== design/pi_controller_antiwindup_unit.sv =====
// pi_controller_antiwindup_unit: fixed-point PI controller with conditional integration.
// Depends on piaw_pkg, piaw_if.sv (stream interfaces) and piaw_sequencer.sv.
//
// Usage:
//   sample_i carries setpoint and measured; one transfer there yields exactly one
//   transfer on result_o with control_output (Q16.16, clamped to +-limit) and
//   clamp_state (none / upper / lower).
//   Configuration: cfg_we_i with cfg_idx_i selects kp, inv_ti, sample_period or
//   output_limit; cfg_data_i keeps only the register's low bits. Any write also
//   clears the integral accumulator. Write only while no sample is in flight.
//   Program: a 10-step control program runs per sample on a single shared 32x24
//   multiplier (error*period, then the accumulator*inv_ti and total*kp products
//   in two halves each). The result is registered at the last step; the next
//   sample is taken only when the program is back at its first step, so a new
//   sample is not accepted before the last one is through the program.
//   The result sits in an output register: a new sample is accepted while it
//   waits; the program holds at its last step while the output register is
//   still full, so a stalled receiver stops the block after one more sample.
//   Reset: accumulator 0, kp = inv_ti = sample_period = 0, output_limit = 1.0,
//   no result pending, program at its first step.
module pi_controller_antiwindup_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [piaw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [piaw_pkg::CfgDataW-1:0] cfg_data_i,
  piaw_sample_if.sink                   sample_i,
  piaw_result_if.source                 result_o
);

  localparam int W        = piaw_pkg::AccWidth;
  localparam int F        = piaw_pkg::AccFracBits;
  // error*period has 24 fraction bits; align to F
  localparam int StepProdW = piaw_pkg::SampleW + piaw_pkg::PeriodW;
  localparam int ShL       = (F >= 24) ? F - 24 : 0;
  localparam int ShR       = (F < 24) ? 24 - F : 0;
  localparam int SmagW     = StepProdW + ShL;
  localparam int SumW      = ((W > SmagW) ? W : SmagW) + 2;
  localparam int FullW     = piaw_pkg::ProdW + piaw_pkg::MulAW;
  localparam int TotW      = piaw_pkg::CapW + 3;
  localparam int OutvW     = piaw_pkg::CapW + 1;

  localparam logic signed [SumW-1:0] AccMaxS = {{(SumW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SumW-1:0] AccMinS = {{(SumW-W+1){1'b1}}, {(W-1){1'b0}}};

  // floor((lo + hi*2^32) / 2^shift), capped at 2^62
  function automatic logic [piaw_pkg::CapW-1:0] mul_cap(
    input logic [piaw_pkg::ProdW-1:0] lo,
    input logic [piaw_pkg::ProdW-1:0] hi,
    input int                         shift
  );
    logic [FullW-1:0] full;
    logic [FullW-1:0] r;
    full = FullW'(lo) + (FullW'(hi) << piaw_pkg::MulAW);
    r    = full >> shift;
    if (r > FullW'(piaw_pkg::BigCap)) return piaw_pkg::BigCap;
    return r[piaw_pkg::CapW-1:0];
  endfunction

  // ---------------- sequencer ----------------
  piaw_pkg::seq_cond_t cond;
  piaw_pkg::seq_out_t  seq;
  logic                out_valid_q;
  logic                out_free;
  logic                sample_fire;
  logic                op_go_out;

  assign out_free      = !out_valid_q || result_o.ready;
  assign cond.in_valid = sample_i.valid;
  assign cond.out_free = out_free;

  piaw_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .seq_o  (seq)
  );

  assign sample_i.ready = (seq.word.seq == piaw_pkg::SEQ_WAIT_IN);
  assign sample_fire    = sample_i.valid && sample_i.ready;
  assign op_go_out      = seq.go && (seq.word.op == piaw_pkg::OP_OUT);

  // ---------------- registers ----------------
  logic [piaw_pkg::KpW-1:0]     kp_q;
  logic [piaw_pkg::InvTiW-1:0]  inv_ti_q;
  logic [piaw_pkg::PeriodW-1:0] period_q;
  logic [piaw_pkg::LimitW-1:0]  limit_q;
  logic signed [W-1:0]          acc_q;

  logic signed [piaw_pkg::ErrW-1:0] err_q;
  logic [piaw_pkg::ProdW-1:0]       prod_q, plo_q;
  logic signed [W-1:0]              tent_q;
  logic [W-1:0]                     tmag_q;
  logic                             tneg_q;
  logic [piaw_pkg::CapW-1:0]        imag_q;
  logic [piaw_pkg::CapW-1:0]        tot_mag_q;
  logic                             tot_neg_q;
  logic signed [piaw_pkg::OutW-1:0] out_data_q;
  piaw_pkg::clamp_e                 out_clamp_q;

  // ---------------- shared multiplier ----------------
  logic [piaw_pkg::SampleW-1:0] err_mag;
  logic                         err_neg;
  logic [63:0]                  tmag_ext, totm_ext;
  logic [piaw_pkg::MulAW-1:0]   mul_a;
  logic [piaw_pkg::MulBW-1:0]   mul_b;

  assign err_neg  = err_q[piaw_pkg::ErrW-1];
  assign err_mag  = err_neg ? piaw_pkg::SampleW'(-err_q) : piaw_pkg::SampleW'(err_q);
  assign tmag_ext = 64'(tmag_q);
  assign totm_ext = 64'(tot_mag_q);

  always_comb begin
    unique case (seq.word.mul_sel)
      piaw_pkg::MUL_ERR_PERIOD: begin
        mul_a = piaw_pkg::MulAW'(err_mag);
        mul_b = period_q;
      end
      piaw_pkg::MUL_TENT_LO: begin
        mul_a = tmag_ext[31:0];
        mul_b = inv_ti_q;
      end
      piaw_pkg::MUL_TENT_HI: begin
        mul_a = tmag_ext[63:32];
        mul_b = inv_ti_q;
      end
      piaw_pkg::MUL_TOT_LO: begin
        mul_a = totm_ext[31:0];
        mul_b = kp_q;
      end
      piaw_pkg::MUL_TOT_HI: begin
        mul_a = totm_ext[63:32];
        mul_b = kp_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- datapath operations ----------------
  logic signed [piaw_pkg::ErrW-1:0] err_d;
  logic [SmagW-1:0]                 smag;
  logic signed [SumW-1:0]           step_s, sum_s;
  logic signed [W-1:0]              tent_d;
  logic [W-1:0]                     tmag_d;
  logic signed [TotW-1:0]           integ_s, total_s;
  logic [TotW-1:0]                  total_mag;
  logic [piaw_pkg::CapW-1:0]        tot_mag_d;
  logic [piaw_pkg::CapW-1:0]        omag;
  logic signed [OutvW-1:0]          outv, lim_s, res_s;
  piaw_pkg::clamp_e                 clamp_d;
  logic                             commit;

  assign err_d = $signed({1'b0, sample_i.setpoint}) - $signed({1'b0, sample_i.measured});

  // tentative integration step, saturating at the accumulator width
  always_comb begin
    smag   = (SmagW'(prod_q[StepProdW-1:0]) << ShL) >> ShR;
    step_s = err_neg ? -$signed(SumW'(smag)) : $signed(SumW'(smag));
    sum_s  = SumW'(acc_q) + step_s;
    if (sum_s > AccMaxS) begin
      tent_d = AccMaxS[W-1:0];
    end else if (sum_s < AccMinS) begin
      tent_d = AccMinS[W-1:0];
    end else begin
      tent_d = sum_s[W-1:0];
    end
    tmag_d = tent_d[W-1] ? (~tent_d + 1'b1) : tent_d;
  end

  // error (Q16 aligned) plus integral term, magnitude capped
  always_comb begin
    integ_s   = tneg_q ? -$signed(TotW'(imag_q)) : $signed(TotW'(imag_q));
    total_s   = (TotW'(err_q) <<< 16) + integ_s;
    total_mag = total_s[TotW-1] ? TotW'(-total_s) : TotW'(total_s);
    tot_mag_d = (total_mag > TotW'(piaw_pkg::BigCap)) ? piaw_pkg::BigCap
                                                      : total_mag[piaw_pkg::CapW-1:0];
  end

  // kp product, sign and clamp against the limit
  always_comb begin
    omag  = mul_cap(plo_q, prod_q, piaw_pkg::KpShift);
    outv  = tot_neg_q ? -$signed(OutvW'(omag)) : $signed(OutvW'(omag));
    lim_s = $signed(OutvW'(limit_q));
    priority if (outv >= lim_s) begin
      res_s   = lim_s;
      clamp_d = piaw_pkg::CLAMP_UPPER;
    end else if (outv <= -lim_s) begin
      res_s   = -lim_s;
      clamp_d = piaw_pkg::CLAMP_LOWER;
    end else begin
      res_s   = outv;
      clamp_d = piaw_pkg::CLAMP_NONE;
    end
  end

  assign commit = op_go_out && (clamp_d == piaw_pkg::CLAMP_NONE);

  // control state, configuration and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      inv_ti_q    <= '0;
      period_q    <= '0;
      limit_q     <= piaw_pkg::LimitReset;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (piaw_pkg::reg_idx_e'(cfg_idx_i))
          piaw_pkg::REG_KP:     kp_q     <= cfg_data_i[piaw_pkg::KpW-1:0];
          piaw_pkg::REG_INV_TI: inv_ti_q <= cfg_data_i[piaw_pkg::InvTiW-1:0];
          piaw_pkg::REG_PERIOD: period_q <= cfg_data_i[piaw_pkg::PeriodW-1:0];
          piaw_pkg::REG_LIMIT:  limit_q  <= cfg_data_i[piaw_pkg::LimitW-1:0];
        endcase
        acc_q <= '0;
      end else if (commit) begin
        acc_q <= tent_q;
      end
      if (op_go_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers; the product holds while a step waits so the kp product
  // survives a stalled output register
  always_ff @(posedge clk_i) begin
    if (seq.go) begin
      prod_q <= piaw_pkg::ProdW'(mul_a) * piaw_pkg::ProdW'(mul_b);
    end
    if (seq.word.plo_en) begin
      plo_q <= prod_q;
    end
    if (seq.go) begin
      unique case (seq.word.op)
        piaw_pkg::OP_NONE: ;
        piaw_pkg::OP_LOAD: err_q <= err_d;
        piaw_pkg::OP_TENT: begin
          tent_q <= tent_d;
          tmag_q <= tmag_d;
          tneg_q <= tent_d[W-1];
        end
        piaw_pkg::OP_INTEG: imag_q <= mul_cap(plo_q, prod_q, piaw_pkg::IntegShift);
        piaw_pkg::OP_TOTAL: begin
          tot_mag_q <= tot_mag_d;
          tot_neg_q <= total_s[TotW-1];
        end
        piaw_pkg::OP_OUT: begin
          out_data_q  <= res_s[piaw_pkg::OutW-1:0];
          out_clamp_q <= clamp_d;
        end
        default: ;
      endcase
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.control_output = out_data_q;
  assign result_o.clamp_state    = out_clamp_q;

  // ---------------- assertions ----------------
  // a sample transfer starts the program, so no second one follows at once
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_fire |=> !sample_i.ready)
    else $error("sample taken while another is in flight");

  // the accumulator moves only on a commit or a configuration write
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !commit) |=> $stable(acc_q))
    else $error("accumulator changed without commit");

  // an upper clamp never reports a negative drive
  a_upper_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.clamp_state == piaw_pkg::CLAMP_UPPER)
      |-> !result_o.control_output[piaw_pkg::OutW-1])
    else $error("upper clamp with negative output");

  // a lower clamp never reports a positive drive
  a_lower_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.clamp_state == piaw_pkg::CLAMP_LOWER)
      |-> (result_o.control_output[piaw_pkg::OutW-1] || result_o.control_output == '0))
    else $error("lower clamp with positive output");

  // only the three defined clamp codes leave the block
  a_clamp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.clamp_state != 2'd3))
    else $error("undefined clamp code");

endmodule
